[rtl/core/dhp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_pkg: shared types and constants of the heaviest path update core
// field widths, stream packing sizes and the classified item flags
// ----------------------------------------------------------------------------
package dhp_pkg;

	localparam int IDX_W         = 10;   // node and ancestor index
	localparam int WGT_W         = 32;   // node weight, signed q16.16
	localparam int SUM_W         = 48;   // path total, signed q32.16
	localparam int LEN_W         = 11;   // path length
	localparam int MAX_NODES_DEF = 1024;
	localparam int QUEUE_DEPTH   = 4;

	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USER_W = 2;

	localparam logic [LEN_W-1:0]        LEN_SAT = '1;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// what the front end found out about one item
	typedef struct packed {
		logic start;    // node numbering restarts with this item
		logic usable;   // names an ancestor below the current node
		logic err;      // named an ancestor not below the current node
		logic last;     // closes the current node
	} item_flags_t;

	localparam int FLAGS_W = $bits(item_flags_t);

endpackage
`default_nettype wire

[rtl/core/dhp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_ram: simple dual port ram
// one write port, one read port with registered data, read before write
// ----------------------------------------------------------------------------
module dhp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/dhp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_front: item intake and classification
// numbers the nodes, checks ancestor order and hands items to the queue
// ----------------------------------------------------------------------------
module dhp_front #(
	parameter int MAX_NODES = dhp_pkg::MAX_NODES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            in_start,
	input  wire logic                            in_has_anc,
	input  wire logic [dhp_pkg::IDX_W-1:0]       in_anc,
	input  wire logic [dhp_pkg::WGT_W-1:0]       in_weight,
	input  wire logic                            in_last,
	input  wire logic                            q_ready,
	output logic                                 push,
	output dhp_pkg::item_flags_t                 push_flags,
	output logic [dhp_pkg::IDX_W-1:0]            push_anc,
	output logic [dhp_pkg::WGT_W-1:0]            push_weight,
	output logic [$clog2(MAX_NODES)-1:0]         push_cnt
);

	import dhp_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = (NW > IDX_W) ? NW : IDX_W;
	localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

	logic [NW-1:0] cnt_q;
	logic [NW-1:0] cnt_cur;
	logic          accept;
	logic          order_bad;

	assign in_ready  = q_ready;
	assign accept    = in_valid & q_ready;
	assign cnt_cur   = in_start ? '0 : cnt_q;
	assign order_bad = in_has_anc & (CW'(in_anc) >= CW'(cnt_cur));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				cnt_q <= (cnt_cur == LAST_IDX) ? '0 : cnt_cur + 1'b1;
			end else begin
				cnt_q <= cnt_cur;
			end
		end
	end

	assign push              = accept;
	assign push_flags.start  = in_start;
	assign push_flags.usable = in_has_anc & ~order_bad;
	assign push_flags.err    = order_bad;
	assign push_flags.last   = in_last;
	assign push_anc          = in_anc;
	assign push_weight       = in_weight;
	assign push_cnt          = cnt_cur;

endmodule
`default_nettype wire

[rtl/core/dhp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_queue: short fifo between front and back end
// register based, head entry visible while not empty
// ----------------------------------------------------------------------------
module dhp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  ready,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head_data,
	output logic                  not_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PW-1:0]    LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready     = (count_q != FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push & ready;
	assign do_pop    = pop & not_empty;
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

[rtl/core/dhp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_back: node table lookup, best ancestor selection and result build
// s1 picks the best ancestor, s2 adds the node weight and writes the table
// ----------------------------------------------------------------------------
module dhp_back #(
	parameter int MAX_NODES = dhp_pkg::MAX_NODES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_valid,
	output logic                                 q_pop,
	input  wire dhp_pkg::item_flags_t            q_flags,
	input  wire logic [dhp_pkg::IDX_W-1:0]       q_anc,
	input  wire logic [dhp_pkg::WGT_W-1:0]       q_weight,
	input  wire logic [$clog2(MAX_NODES)-1:0]    q_cnt,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [dhp_pkg::IDX_W-1:0]            out_node_index,
	output logic [dhp_pkg::SUM_W-1:0]            out_path_weight,
	output logic [dhp_pkg::LEN_W-1:0]            out_path_len,
	output logic                                 out_has_best,
	output logic [dhp_pkg::IDX_W-1:0]            out_pred_index,
	output logic                                 out_order_error
);

	import dhp_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int RW = SUM_W + LEN_W;

	logic adv;

	// stage 1
	logic                    s1_valid;
	item_flags_t             s1_flags;
	logic [NW-1:0]           s1_anc;
	logic [WGT_W-1:0]        s1_weight;
	logic [NW-1:0]           s1_cnt;

	// node being built
	logic signed [SUM_W-1:0] run_w_q;
	logic [LEN_W-1:0]        run_l_q;
	logic [NW-1:0]           run_i_q;
	logic                    run_v_q;
	logic                    run_e_q;

	// stage 2
	logic                    s2_valid;
	logic [NW-1:0]           s2_cnt;
	logic [WGT_W-1:0]        s2_weight;
	logic                    s2_rv;
	logic signed [SUM_W-1:0] s2_bw;
	logic [LEN_W-1:0]        s2_bl;
	logic [NW-1:0]           s2_bi;
	logic                    s2_re;

	// last table write
	logic                    lw_valid_q;
	logic [NW-1:0]           lw_idx_q;
	logic signed [SUM_W-1:0] lw_w_q;
	logic [LEN_W-1:0]        lw_l_q;

	logic                    m_valid_q;

	logic [NW-1:0]           rd_addr;
	logic [RW-1:0]           rd_data;
	logic signed [SUM_W-1:0] ram_w;
	logic [LEN_W-1:0]        ram_l;

	logic signed [SUM_W:0]   c_sum;
	logic signed [SUM_W-1:0] c_total;
	logic [LEN_W:0]          c_len_inc;
	logic [LEN_W-1:0]        c_len;

	logic signed [SUM_W-1:0] cand_w;
	logic [LEN_W-1:0]        cand_l;
	logic signed [SUM_W-1:0] bw_e;
	logic [LEN_W-1:0]        bl_e;
	logic [NW-1:0]           bi_e;
	logic                    rv_e;
	logic                    re_e;
	logic                    take;
	logic signed [SUM_W-1:0] n_w;
	logic [LEN_W-1:0]        n_l;
	logic [NW-1:0]           n_i;
	logic                    n_v;
	logic                    n_e;

	assign adv   = ~m_valid_q | out_ready;
	assign q_pop = adv & q_valid;

	// keep the stalled item's address so its read data stays put
	assign rd_addr = adv ? NW'(q_anc) : s1_anc;

	dhp_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_NODES)
	) u_table (
		.clk   (clk),
		.we    (adv & s2_valid),
		.waddr (s2_cnt),
		.wdata ({c_len, c_total}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign ram_w = rd_data[SUM_W-1:0];
	assign ram_l = rd_data[RW-1:SUM_W];

	// finishing add with saturation
	always_comb begin
		c_sum     = {s2_bw[SUM_W-1], s2_bw}
		          + {{(SUM_W+1-WGT_W){s2_weight[WGT_W-1]}}, s2_weight};
		c_len_inc = {1'b0, s2_bl} + 1'b1;
		if (!s2_rv) begin
			c_total = {{(SUM_W-WGT_W){s2_weight[WGT_W-1]}}, s2_weight};
			c_len   = LEN_W'(1);
		end else begin
			if (c_sum[SUM_W] != c_sum[SUM_W-1]) begin
				c_total = c_sum[SUM_W] ? SUM_MIN : SUM_MAX;
			end else begin
				c_total = c_sum[SUM_W-1:0];
			end
			c_len = c_len_inc[LEN_W] ? LEN_SAT : c_len_inc[LEN_W-1:0];
		end
	end

	// ancestor entry: newest write first, then the table
	always_comb begin
		if (s2_valid && (s2_cnt == s1_anc)) begin
			cand_w = c_total;
			cand_l = c_len;
		end else if (lw_valid_q && (lw_idx_q == s1_anc)) begin
			cand_w = lw_w_q;
			cand_l = lw_l_q;
		end else begin
			cand_w = ram_w;
			cand_l = ram_l;
		end
	end

	// best ancestor update
	always_comb begin
		rv_e = s1_flags.start ? 1'b0 : run_v_q;
		re_e = s1_flags.start ? 1'b0 : run_e_q;
		bw_e = run_w_q;
		bl_e = run_l_q;
		bi_e = run_i_q;
		take = s1_flags.usable &
		       (~rv_e | (cand_w > bw_e) | ((cand_w == bw_e) & (s1_anc < bi_e)));
		n_w  = take ? cand_w : bw_e;
		n_l  = take ? cand_l : bl_e;
		n_i  = take ? s1_anc : bi_e;
		n_v  = rv_e | take;
		n_e  = re_e | s1_flags.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			s2_valid   <= 1'b0;
			run_v_q    <= 1'b0;
			run_e_q    <= 1'b0;
			lw_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else if (adv) begin
			s1_valid  <= q_valid;
			s2_valid  <= s1_valid & s1_flags.last;
			m_valid_q <= s2_valid;
			if (s2_valid) begin
				lw_valid_q <= 1'b1;
			end
			if (s1_valid) begin
				if (s1_flags.last) begin
					run_v_q <= 1'b0;
					run_e_q <= 1'b0;
				end else begin
					run_v_q <= n_v;
					run_e_q <= n_e;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_valid) begin
				s1_flags  <= q_flags;
				s1_anc    <= NW'(q_anc);
				s1_weight <= q_weight;
				s1_cnt    <= q_cnt;
			end
			if (s1_valid) begin
				run_w_q <= n_w;
				run_l_q <= n_l;
				run_i_q <= n_i;
				if (s1_flags.last) begin
					s2_cnt    <= s1_cnt;
					s2_weight <= s1_weight;
					s2_rv     <= n_v;
					s2_bw     <= n_w;
					s2_bl     <= n_l;
					s2_bi     <= n_i;
					s2_re     <= n_e;
				end
			end
			if (s2_valid) begin
				lw_idx_q        <= s2_cnt;
				lw_w_q          <= c_total;
				lw_l_q          <= c_len;
				out_node_index  <= IDX_W'(s2_cnt);
				out_path_weight <= c_total;
				out_path_len    <= c_len;
				out_has_best    <= s2_rv;
				out_pred_index  <= s2_rv ? IDX_W'(s2_bi) : '0;
				out_order_error <= s2_re;
			end
		end
	end

	assign out_valid = m_valid_q;

endmodule
`default_nettype wire

[rtl/core/dag_heaviest_path_update_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dag_heaviest_path_update_core: heaviest path over a topologically ordered dag
// keeps per node path total and length, one ancestor edge per item
// ----------------------------------------------------------------------------
// usage
//   input stream: one item per ancestor edge of the current node, nodes in
//   topological order; tlast closes the node and its item carries the node
//   weight. tuser[0] restarts node numbering at zero with this item.
//   output stream: one item per finished node with its path total (signed
//   q32.16, saturating), length, best predecessor and an order error flag.
// throughput and result path
//   one item per cycle sustained while the receiver keeps up; after its
//   closing item is accepted, a node passes through the queue, the selection
//   stage and the finishing stage into the output register. the rate is set
//   by the single node table port pair: one read and one write each cycle,
//   with the two most recent writes forwarded into the selection stage.
// reset and stalls
//   reset clears node numbering and the node in progress; the node table is
//   not cleared, since only nodes finished since a restart are ever looked up.
//   a stalled receiver holds the back end; the four entry queue keeps taking
//   items until it fills, then tready falls.
// ----------------------------------------------------------------------------
module dag_heaviest_path_update_core #(
	parameter int MAX_NODES = dhp_pkg::MAX_NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// node_weight [31:0], ancestor_index [41:32], zero [47:42]
	input  wire logic [dhp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// block_start [0], has_ancestor [1]
	input  wire logic [dhp_pkg::IN_USER_W-1:0]     s_axis_tuser,
	input  wire logic                              s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// node_index [9:0], path_weight [57:10], path_len [68:58],
	// pred_index [78:69], zero [79]
	output logic [dhp_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	// has_pred [0], order_error [1]
	output logic [dhp_pkg::OUT_USER_W-1:0]         m_axis_tuser
);

	import dhp_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int QW = FLAGS_W + WGT_W + IDX_W + NW;

	// front to queue
	logic              q_ready;
	logic              push;
	item_flags_t       push_flags;
	logic [IDX_W-1:0]  push_anc;
	logic [WGT_W-1:0]  push_weight;
	logic [NW-1:0]     push_cnt;

	// queue to back
	logic [QW-1:0]     head_data;
	logic              q_not_empty;
	logic              q_pop;
	item_flags_t       head_flags;
	logic [IDX_W-1:0]  head_anc;
	logic [WGT_W-1:0]  head_weight;
	logic [NW-1:0]     head_cnt;

	// result fields
	logic [IDX_W-1:0]  node_index;
	logic [SUM_W-1:0]  path_weight;
	logic [LEN_W-1:0]  path_len;
	logic              has_pred;
	logic [IDX_W-1:0]  pred_index;
	logic              order_error;

	dhp_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_start    (s_axis_tuser[0]),
		.in_has_anc  (s_axis_tuser[1]),
		.in_anc      (s_axis_tdata[WGT_W +: IDX_W]),
		.in_weight   (s_axis_tdata[WGT_W-1:0]),
		.in_last     (s_axis_tlast),
		.q_ready     (q_ready),
		.push        (push),
		.push_flags  (push_flags),
		.push_anc    (push_anc),
		.push_weight (push_weight),
		.push_cnt    (push_cnt)
	);

	dhp_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_flags, push_weight, push_anc, push_cnt}),
		.ready     (q_ready),
		.pop       (q_pop),
		.head_data (head_data),
		.not_empty (q_not_empty)
	);

	assign {head_flags, head_weight, head_anc, head_cnt} = head_data;

	dhp_back #(
		.MAX_NODES (MAX_NODES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_not_empty),
		.q_pop           (q_pop),
		.q_flags         (head_flags),
		.q_anc           (head_anc),
		.q_weight        (head_weight),
		.q_cnt           (head_cnt),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_node_index  (node_index),
		.out_path_weight (path_weight),
		.out_path_len    (path_len),
		.out_has_best    (has_pred),
		.out_pred_index  (pred_index),
		.out_order_error (order_error)
	);

	// pack result item, lowest field first
	assign m_axis_tdata = {{(OUT_DATA_W - IDX_W - SUM_W - LEN_W - IDX_W){1'b0}},
	                       pred_index, path_len, path_weight, node_index};
	assign m_axis_tuser = {order_error, has_pred};

endmodule
`default_nettype wire

[bench/dag_path_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dag_path_check: result checker for the heaviest path update core
// watches both streams, predicts each finished node from its own copy of the
// node table and compares every returned item field by field
// ----------------------------------------------------------------------------
module dag_path_check (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [dhp_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic [dhp_pkg::IN_USER_W-1:0]  s_tuser,
	input  wire logic                           s_tlast,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [dhp_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire logic [dhp_pkg::OUT_USER_W-1:0] m_tuser,
	output int unsigned                         fail_count,
	output int unsigned                         open_results
);

	import dhp_pkg::*;

	localparam int TABLE_DEPTH = MAX_NODES_DEF;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [SUM_W-1:0] total;
		logic [LEN_W-1:0]        len;
		logic                    has_pred;
		logic [IDX_W-1:0]        pred;
		logic                    order_err;
	} node_result_t;

	// per node totals, only entries finished since the last restart are read
	logic signed [SUM_W-1:0] total_table  [TABLE_DEPTH];
	logic [LEN_W-1:0]        length_table [TABLE_DEPTH];

	// node being built
	logic [IDX_W-1:0]        cur_node;
	logic signed [SUM_W-1:0] cand_total;
	logic [LEN_W-1:0]        cand_len;
	logic [IDX_W-1:0]        cand_idx;
	logic                    cand_found;
	logic                    cand_err;

	node_result_t            finished_nodes_q[$];
	int unsigned             mismatches;

	task automatic clear_candidate();
		cand_total = '0;
		cand_len   = '0;
		cand_idx   = '0;
		cand_found = 1'b0;
		cand_err   = 1'b0;
	endtask

	// one accepted input item: fold in its edge, close the node on tlast
	task automatic fold_item(input logic start, input logic [WGT_W-1:0] wgt,
			input logic has_anc, input logic [IDX_W-1:0] anc, input logic last);
		logic signed [SUM_W-1:0] stored;
		logic signed [SUM_W+1:0] sum;
		logic [LEN_W:0]          len_sum;
		node_result_t            res;
		if (start) begin
			cur_node = '0;
			clear_candidate();
		end
		if (has_anc) begin
			if (anc >= cur_node) begin
				cand_err = 1'b1;
			end else begin
				stored = total_table[anc];
				// equal totals keep the smaller index
				if (!cand_found || stored > cand_total ||
						(stored == cand_total && anc < cand_idx)) begin
					cand_total = stored;
					cand_len   = length_table[anc];
					cand_idx   = anc;
					cand_found = 1'b1;
				end
			end
		end
		if (last) begin
			res.idx       = cur_node;
			res.has_pred  = cand_found;
			res.pred      = cand_found ? cand_idx : '0;
			res.order_err = cand_err;
			if (cand_found) begin
				sum = $signed({{2{cand_total[SUM_W-1]}}, cand_total}) +
					$signed({{(SUM_W+2-WGT_W){wgt[WGT_W-1]}}, wgt});
				if (sum > SUM_MAX)
					res.total = SUM_MAX;
				else if (sum < SUM_MIN)
					res.total = SUM_MIN;
				else
					res.total = sum[SUM_W-1:0];
				len_sum = {1'b0, cand_len} + 1'b1;
				res.len = len_sum[LEN_W] ? LEN_SAT : len_sum[LEN_W-1:0];
			end else begin
				// no usable ancestor: the node starts its own path
				res.total = {{(SUM_W-WGT_W){wgt[WGT_W-1]}}, wgt};
				res.len   = LEN_W'(1);
			end
			total_table[cur_node]  = res.total;
			length_table[cur_node] = res.len;
			finished_nodes_q.insert(finished_nodes_q.size(), res);
			cur_node = (cur_node == IDX_W'(TABLE_DEPTH - 1)) ? '0 : cur_node + 1'b1;
			clear_candidate();
		end
	endtask

	task automatic report_mismatch(input logic [IDX_W-1:0] node, input string field,
			input logic [SUM_W-1:0] seen, input logic [SUM_W-1:0] wanted);
		mismatches++;
		$display("%0t ns: node %0d %s: got %h, expected %h",
			$time, node, field, seen, wanted);
	endtask

	always @(posedge clk or negedge arst_n) begin
		node_result_t got;
		node_result_t want;
		if (!arst_n) begin
			cur_node = '0;
			clear_candidate();
			finished_nodes_q.delete();
			mismatches = 0;
			fail_count   <= 0;
			open_results <= 0;
		end else begin
			if (s_tvalid && s_tready)
				fold_item(s_tuser[0], s_tdata[WGT_W-1:0], s_tuser[1],
					s_tdata[WGT_W +: IDX_W], s_tlast);
			if (m_tvalid && m_tready) begin
				got.idx       = m_tdata[IDX_W-1:0];
				got.total     = m_tdata[IDX_W +: SUM_W];
				got.len       = m_tdata[IDX_W+SUM_W +: LEN_W];
				got.pred      = m_tdata[IDX_W+SUM_W+LEN_W +: IDX_W];
				got.has_pred  = m_tuser[0];
				got.order_err = m_tuser[1];
				if (finished_nodes_q.size() == 0) begin
					report_mismatch(got.idx, "result with nothing awaited", got.total, '0);
				end else begin
					want = finished_nodes_q.pop_front();
					if (got.idx !== want.idx)
						report_mismatch(want.idx, "node_index", SUM_W'(got.idx),
							SUM_W'(want.idx));
					if (got.total !== want.total)
						report_mismatch(want.idx, "path_weight", got.total, want.total);
					if (got.len !== want.len)
						report_mismatch(want.idx, "path_len", SUM_W'(got.len),
							SUM_W'(want.len));
					if (got.has_pred !== want.has_pred)
						report_mismatch(want.idx, "has_pred", SUM_W'(got.has_pred),
							SUM_W'(want.has_pred));
					if (got.pred !== want.pred)
						report_mismatch(want.idx, "pred_index", SUM_W'(got.pred),
							SUM_W'(want.pred));
					if (got.order_err !== want.order_err)
						report_mismatch(want.idx, "order_error", SUM_W'(got.order_err),
							SUM_W'(want.order_err));
				end
			end
			fail_count   <= mismatches;
			open_results <= finished_nodes_q.size();
		end
	end

endmodule

[bench/tb_dag_heaviest_path_update_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dag_heaviest_path_update_core: stimulus and verdict for the path core
// directed edge cases, one block long enough to wrap the node numbering,
// then random node sequences with restarts, broken nodes and bad edges;
// both stream sides idle at random and the receiver holds off once for long
// ----------------------------------------------------------------------------
module tb_dag_heaviest_path_update_core;
	import dhp_pkg::*;

	localparam int NODE_SPAN      = MAX_NODES_DEF;
	localparam int WRAP_NODES     = NODE_SPAN + 24;
	localparam int TARGET_ITEMS   = 1850;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int PRESSURE_ITEMS = 60;
	localparam int SETTLE_CYCLES  = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	int unsigned fail_count;
	int unsigned open_results;

	logic        hold_request;   // asks the receiver for its long hold-off
	bit          tx_fast;        // sender offers back to back
	int unsigned pressure_left;  // items still sent back to back during the hold
	int unsigned items_sent;
	int unsigned node_at;        // node numbering as the block should see it

	dag_heaviest_path_update_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	dag_path_check path_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_axis_tvalid),
		.s_tready     (s_axis_tready),
		.s_tdata      (s_axis_tdata),
		.s_tuser      (s_axis_tuser),
		.s_tlast      (s_axis_tlast),
		.m_tvalid     (m_axis_tvalid),
		.m_tready     (m_axis_tready),
		.m_tdata      (m_axis_tdata),
		.m_tuser      (m_axis_tuser),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("dag_heaviest_path_update_core test failed");
		$finish;
	end

	// mix of extremes, a few repeated values for ties, and full random words
	function automatic logic [WGT_W-1:0] draw_weight();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return WGT_W'($urandom_range(0, 2) << 16);
			default: return $urandom();
		endcase
	endfunction

	// mostly a finished node, sometimes one not below the current node
	function automatic logic [IDX_W-1:0] draw_ancestor(input bit near);
		int unsigned reach;
		if (node_at == 0 || $urandom_range(0, 9) == 0)
			return IDX_W'($urandom_range(node_at, NODE_SPAN - 1));
		if (near) begin
			reach = (node_at > 8) ? 7 : node_at - 1;
			return IDX_W'(node_at - 1 - $urandom_range(0, reach));
		end
		return IDX_W'($urandom_range(0, node_at - 1));
	endfunction

	// offer one item after a random gap and wait for it to be taken
	task automatic offer_edge(input logic start, input logic [WGT_W-1:0] wgt,
			input logic has_anc, input logic [IDX_W-1:0] anc, input logic last);
		int unsigned gap;
		if (pressure_left != 0) begin
			tx_fast = 1'b1;
			pressure_left--;
		end else if (items_sent % 48 == 0) begin
			tx_fast = ($urandom_range(0, 3) == 0);
		end
		gap = tx_fast ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-IDX_W-WGT_W){1'b0}}, anc, wgt};
		s_axis_tuser  <= {has_anc, start};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (start)
			node_at = 0;
		if (last)
			node_at = (node_at == NODE_SPAN - 1) ? 0 : node_at + 1;
	endtask

	// a well formed node with random edges; some nodes name no usable ancestor
	task automatic offer_node(input logic start);
		int unsigned n_items;
		bit          rootless;
		bit          near;
		if (start)
			node_at = 0;
		n_items  = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : $urandom_range(1, 3);
		rootless = ($urandom_range(0, 6) == 0);
		near     = $urandom_range(0, 1);
		for (int k = 0; k < n_items; k++)
			offer_edge(start && k == 0, (k == n_items - 1) ? draw_weight() : $urandom(),
				!rootless && $urandom_range(0, 7) != 0, draw_ancestor(near),
				k == n_items - 1);
	endtask

	// stop offering and wait until every finished node has come back;
	// the count is only read once it includes the item just taken
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
	endtask

	// receiver: random wait after each item, one long hold-off on request
	initial begin : rx_side
		int unsigned idle_left;
		int unsigned hold_left;
		int unsigned taken;
		bit          fast;
		bit          hold_done;
		idle_left = 0;
		hold_left = 0;
		taken     = 0;
		fast      = 1'b0;
		hold_done = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				taken++;
				if (taken % 64 == 0)
					fast = ($urandom_range(0, 2) == 0);
				idle_left = fast ? 0 : $urandom_range(0, 15);
			end
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_left != 0) begin
				idle_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : tx_side
		bit near;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		hold_request  <= 1'b0;
		tx_fast       = 1'b0;
		pressure_left = 0;
		items_sent    = 0;
		node_at       = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes of the weight, no ancestor, self edge, stray item
		offer_edge(1'b1, 32'h7FFF_FFFF, 1'b0, 10'd0, 1'b1);
		offer_edge(1'b0, 32'h8000_0000, 1'b0, 10'd1023, 1'b1);
		offer_edge(1'b0, 32'h1234_5678, 1'b1, 10'd1, 1'b0);
		offer_edge(1'b0, 32'hFFFF_FFFF, 1'b0, 10'd0, 1'b0);
		offer_edge(1'b0, 32'h0000_0000, 1'b1, 10'd0, 1'b0);
		offer_edge(1'b0, 32'h0001_0000, 1'b1, 10'd2, 1'b1);
		// two roots with equal totals, then ties from both orders
		offer_edge(1'b0, 32'h0001_0000, 1'b0, 10'd0, 1'b1);
		offer_edge(1'b0, 32'h0001_0000, 1'b0, 10'd0, 1'b1);
		offer_edge(1'b0, 32'h0000_8000, 1'b1, 10'd4, 1'b0);
		offer_edge(1'b0, 32'h0000_8000, 1'b1, 10'd3, 1'b1);
		offer_edge(1'b0, 32'hFFFF_FFFF, 1'b1, 10'd3, 1'b0);
		offer_edge(1'b0, 32'hFFFF_FFFF, 1'b1, 10'd4, 1'b1);
		// only edge far above the node: flagged, node starts its own path
		offer_edge(1'b0, 32'hFFFF_0000, 1'b1, 10'd1023, 1'b1);
		// partial node thrown away by a restart on a closing item
		offer_edge(1'b0, 32'h7FFF_FFFF, 1'b1, 10'd0, 1'b0);
		offer_edge(1'b1, 32'hFFFF_FFFF, 1'b0, 10'd0, 1'b1);
		// chain of largest then smallest weights
		offer_edge(1'b0, 32'h7FFF_FFFF, 1'b1, 10'd0, 1'b1);
		offer_edge(1'b0, 32'h7FFF_FFFF, 1'b1, 10'd1, 1'b1);
		offer_edge(1'b0, 32'h8000_0000, 1'b1, 10'd2, 1'b1);
		drain_results();

		// one block past the end of the numbering, single item nodes,
		// with the receiver holding off partway through
		for (int n = 0; n < WRAP_NODES; n++) begin
			if (n == 300) begin
				hold_request  <= 1'b1;
				pressure_left = PRESSURE_ITEMS;
			end
			near = ($urandom_range(0, 9) < 7);
			offer_edge(n == 0, draw_weight(), $urandom_range(0, 9) != 0,
				draw_ancestor(near), 1'b1);
		end
		drain_results();

		// random node sequences with restarts and broken nodes
		while (items_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 2))
					offer_edge(1'b0, $urandom(), 1'b1, draw_ancestor(1'b0), 1'b0);
				offer_node(1'b1);
			end else begin
				offer_node($urandom_range(0, 14) == 0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_results == 0)
			$display("dag_heaviest_path_update_core test passed");
		else
			$display("dag_heaviest_path_update_core test failed");
		$finish;
	end

endmodule

[dag_heaviest_path_update_core.f]
rtl/core/dhp_pkg.sv
rtl/core/dhp_ram.sv
rtl/core/dhp_front.sv
rtl/core/dhp_queue.sv
rtl/core/dhp_back.sv
rtl/core/dag_heaviest_path_update_core.sv
bench/dag_path_check.sv
bench/tb_dag_heaviest_path_update_core.sv
